>>> hw/rtl/next_use_distance_fifo_macros.svh
// assertion macros for the next-use fifo
`ifndef NEXT_USE_DISTANCE_FIFO_MACROS_SVH
`define NEXT_USE_DISTANCE_FIFO_MACROS_SVH
// assert that a implies b in the same cycle
`define NUD_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// assert that a implies b in the next cycle
`define NUD_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> hw/rtl/nudf_pkg.sv
// shared types for the next-use fifo
`timescale 1ns / 1ps
package nudf_pkg;
	typedef struct packed {
		logic        push_valid;
		logic [9:0]  elem_group;
		logic [9:0]  elem_row;
		logic [9:0]  elem_col;
		logic [31:0] elem_value;
		logic        take;
		logic [9:0]  query_col;
	} nudf_in_t;

	typedef struct packed {
		logic        out_valid;
		logic [9:0]  out_group;
		logic [9:0]  out_row;
		logic [9:0]  out_col;
		logic [31:0] out_value;
		logic        out_next_valid;
		logic [15:0] out_next_pos;
		logic        query_valid;
		logic [15:0] query_pos;
		logic        push_dropped;
	} nudf_out_t;
endpackage

>>> hw/rtl/next_use_distance_fifo.sv
// top level: next-use look-ahead fifo with valid/stall channels
`timescale 1ns / 1ps
// usage:
// - input channel in_valid/in_stall carries one tick transaction (push, take,
//   query) as a packed struct
// - output channel out_valid/out_stall returns the tick's result transaction
// - the front accepts a transaction into a one-entry queue; the back engine
//   runs the memory read-modify-write sequence for it
// - an accepted transaction runs through ST_RD, ST_PUSH, ST_PRD and, when the
//   tick pops, ST_POP in the engine; its result is then registered at the output,
//   and the next transaction starts only after that result is registered
// - after reset a clearing pass empties the next-use and pending-count column
//   memories; no transaction starts until it ends
// - when the receiver stalls the finished result is held in the output
//   register and the engine stops; the front keeps one queued transaction
`include "next_use_distance_fifo_macros.svh"
module next_use_distance_fifo import nudf_pkg::*; #(
	parameter int NUM_COLS   = 1024,
	parameter int FIFO_DEPTH = 256,
	parameter int POS_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  nudf_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output nudf_out_t out_data
);
	// front queue
	logic q_full_q;
	nudf_in_t q_data_q;
	logic go, done, busy_q;
	nudf_out_t res;

	assign in_stall = q_full_q;
	assign go = q_full_q && !busy_q && !(out_valid && out_stall) && done;

	nudf_core #(.NUM_COLS(NUM_COLS), .FIFO_DEPTH(FIFO_DEPTH), .POS_BITS(POS_BITS))
		u_core (.clk, .arst_n, .go, .din(q_data_q), .done, .dout(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_full_q <= 1'b0; q_data_q <= '0; busy_q <= 1'b0; out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (in_valid && !in_stall) begin
				q_full_q <= 1'b1; q_data_q <= in_data;
			end
			if (go) begin
				q_full_q <= 1'b0; busy_q <= 1'b1;
			end else if (busy_q && done) begin
				busy_q <= 1'b0; out_valid <= 1'b1; out_data <= res;
			end
		end
	end

	`NUD_ASSERT_NEXT(a_go_busy, clk, arst_n, go, busy_q, "engine not busy after start")
	`NUD_ASSERT_IMP(a_no_go_stall, clk, arst_n, out_valid && out_stall, !go,
		"start while output stalled")
	`NUD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result lost under stall")
endmodule

>>> hw/rtl/nudf_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module nudf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/nudf_core.sv
// tick-by-tick engine: one step of the model per accepted transaction
`timescale 1ns / 1ps
module nudf_core import nudf_pkg::*; #(
	parameter int NUM_COLS   = 1024,
	parameter int FIFO_DEPTH = 256,
	parameter int POS_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  nudf_in_t  din,
	output logic      done,
	output nudf_out_t dout
);
	localparam int SW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int EW = 62;
	localparam int LW = POS_BITS + 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_PUSH = 5'b00100,
		ST_PRD  = 5'b01000,
		ST_POP  = 5'b10000
	} st_t;

	st_t state_q;
	nudf_in_t in_q;
	logic [SW-1:0] head_q, tail_q;
	logic [FW-1:0] fill_q;
	logic [POS_BITS-1:0] arr_q;
	logic held_q, drop_q;
	logic [EW-1:0] held_e_q;
	logic [LW-1:0] held_n_q;
	logic [CW:0] clr_q;
	logic clearing;

	// per-column memories: next-use, last slot, pending count
	logic nu_we, ls_we, pd_we;
	logic [CW-1:0] nu_wa, nu_ra, ls_wa, pd_wa, key_q, ra_col;
	logic [LW-1:0] nu_wd, nu_rd;
	logic [SW-1:0] ls_wd, ls_rd;
	logic [FW-1:0] pd_wd, pd_rd;
	logic es_we, nl_we;
	logic [SW-1:0] es_wa, nl_wa, s_ra;
	logic [EW-1:0] es_wd, es_rd;
	logic [LW-1:0] nl_wd, nl_rd;
	logic [CW-1:0] push_key, pop_key, q_key;
	logic [POS_BITS-1:0] pos;
	logic [EW-1:0] push_e, pop_e;
	logic byp_q;

	assign clearing = !clr_q[CW];
	assign push_e   = {in_q.elem_group, in_q.elem_row, in_q.elem_col, in_q.elem_value};
	// a push into an empty fifo pops in the same tick; the ram read is stale then
	assign pop_e    = byp_q ? push_e : es_rd;
	assign push_key = CW'(in_q.elem_col % NUM_COLS);
	assign pop_key  = CW'(pop_e[41:32] % NUM_COLS);
	assign q_key    = CW'(in_q.query_col);
	assign pos = arr_q;

	nudf_ram #(.WIDTH(LW), .DEPTH(NUM_COLS)) u_nu (.clk, .we(nu_we), .waddr(nu_wa),
		.wdata(nu_wd), .raddr(nu_ra), .rdata(nu_rd));
	nudf_ram #(.WIDTH(SW), .DEPTH(NUM_COLS)) u_ls (.clk, .we(ls_we), .waddr(ls_wa),
		.wdata(ls_wd), .raddr(ra_col), .rdata(ls_rd));
	nudf_ram #(.WIDTH(FW), .DEPTH(NUM_COLS)) u_pd (.clk, .we(pd_we), .waddr(pd_wa),
		.wdata(pd_wd), .raddr(ra_col), .rdata(pd_rd));
	nudf_ram #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_es (.clk, .we(es_we), .waddr(es_wa),
		.wdata(es_wd), .raddr(s_ra), .rdata(es_rd));
	nudf_ram #(.WIDTH(LW), .DEPTH(FIFO_DEPTH)) u_nl (.clk, .we(nl_we), .waddr(nl_wa),
		.wdata(nl_wd), .raddr(s_ra), .rdata(nl_rd));

	logic do_push, full;
	assign full = (fill_q >= FW'(FIFO_DEPTH));
	assign do_push = in_q.push_valid && !full;

	// second link write (clear tail link) happens in ST_PRD
	logic tail_link_q;
	logic [SW-1:0] tail_slot_q;

	always_comb begin
		nu_we = 1'b0; nu_wa = clr_q[CW-1:0]; nu_wd = '0;
		ls_we = 1'b0; ls_wa = push_key; ls_wd = tail_q;
		pd_we = 1'b0; pd_wa = clr_q[CW-1:0]; pd_wd = '0;
		es_we = 1'b0; es_wa = tail_q;
		es_wd = push_e;
		nl_we = 1'b0; nl_wa = tail_q; nl_wd = '0;
		ra_col = push_key; s_ra = head_q; nu_ra = q_key;
		if (clearing) begin
			nu_we = 1'b1; pd_we = 1'b1;
		end
		case (state_q)
			ST_PUSH: begin
				if (do_push) begin
					es_we = 1'b1; nl_we = 1'b1;
					ls_we = 1'b1;
					pd_we = 1'b1; pd_wa = push_key; pd_wd = pd_rd + 1'b1;
					if (pd_rd == '0) begin
						nu_we = 1'b1; nu_wa = push_key; nu_wd = {1'b1, pos};
					end
				end
			end
			ST_PRD: begin
				ra_col = pop_key;
				if (tail_link_q) begin
					nl_we = 1'b1; nl_wa = tail_slot_q;
				end
			end
			ST_POP: begin
				ra_col = key_q;
				pd_wa = key_q; pd_we = 1'b1;
				pd_wd = (pd_rd != '0) ? pd_rd - 1'b1 : pd_rd;
				nu_we = 1'b1; nu_wa = key_q; nu_wd = nl_rd;
			end
			default: ;
		endcase
		// link write from push goes to last slot of the column
		if (state_q == ST_PUSH && do_push && pd_rd != '0) begin
			nl_wa = ls_rd; nl_wd = {1'b1, pos};
		end
	end

	// query read lands before the pop write; forward the popped column's entry
	logic qfw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; head_q <= '0; tail_q <= '0; fill_q <= '0;
			arr_q <= '0; held_q <= 1'b0; held_e_q <= '0; held_n_q <= '0;
			clr_q <= '0; drop_q <= 1'b0; key_q <= '0; in_q <= '0;
			tail_link_q <= 1'b0; tail_slot_q <= '0; byp_q <= 1'b0; qfw_q <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			qfw_q <= (state_q == ST_POP) && (q_key == key_q);
			case (state_q)
				ST_IDLE: if (go && !clearing) begin
					in_q <= din; state_q <= ST_RD;
					if (din.take) begin
						held_q <= 1'b0; held_e_q <= '0; held_n_q <= '0;
					end
				end
				ST_RD: state_q <= ST_PUSH;
				ST_PUSH: begin
					drop_q <= in_q.push_valid && full;
					tail_link_q <= do_push && (pd_rd != '0);
					tail_slot_q <= tail_q;
					byp_q <= do_push && (fill_q == '0);
					if (do_push) begin
						tail_q <= (tail_q == SW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
						fill_q <= fill_q + 1'b1;
						arr_q <= arr_q + 1'b1;
					end
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					tail_link_q <= 1'b0;
					if (!held_q && fill_q != '0) begin
						key_q <= pop_key;
						held_e_q <= pop_e;
						held_q <= 1'b1;
						head_q <= (head_q == SW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
						fill_q <= fill_q - 1'b1;
						state_q <= ST_POP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					held_n_q <= nl_rd;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query result
	logic qv;
	logic [LW-1:0] q_nu;
	assign q_nu = qfw_q ? held_n_q : nu_rd;
	assign qv = (32'(in_q.query_col) < NUM_COLS) && q_nu[LW-1];
	assign done = (state_q == ST_IDLE) && !clearing;
	always_comb begin
		dout.out_valid      = held_q;
		dout.out_group      = held_e_q[61:52];
		dout.out_row        = held_e_q[51:42];
		dout.out_col        = held_e_q[41:32];
		dout.out_value      = held_e_q[31:0];
		dout.out_next_valid = held_n_q[LW-1];
		dout.out_next_pos   = held_n_q[LW-1] ? 16'(held_n_q[POS_BITS-1:0]) : '0;
		dout.query_valid    = qv;
		dout.query_pos      = qv ? 16'(q_nu[POS_BITS-1:0]) : '0;
		dout.push_dropped   = drop_q;
	end
endmodule
